// ===== src/snr_pkg.sv =====
// Shared types and constants for the surface net radiation block.
// No dependencies; used by snr_cfg, snr_pipe and surface_net_radiation_top.
package snr_pkg;

  localparam int KIN_W = 27;
  localparam int EATM_W = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TSW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZEN = 2'd2;

  localparam logic [15:0] TSW_RESET = 16'd45875;
  localparam logic [8:0] DOY_RESET = 9'd1;
  localparam logic [13:0] ZEN_RESET = 14'd4500;

  // sqrt(sigma) scaled so that (T^2 * K) >> 30 is the flux root in Q24
  localparam logic [31:0] SQRT_SIGMA_K = 32'd428954570;

  typedef struct packed {
    logic              ok;
    logic [KIN_W-1:0]  kin;
    logic [EATM_W-1:0] eatm;
  } snr_coef_t;

endpackage

// ===== src/snr_cfg.sv =====
// Configuration registers and the per-image coefficient sequencer.
// Depends on snr_pkg; computes incoming shortwave and atmospheric emissivity.
module snr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [snr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output snr_pkg::snr_coef_t               coef
);

  localparam logic [32:0] ONE_Q30 = 33'd1073741824;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [31:0] RAD_CDEG = 32'd187403;
  localparam logic [31:0] RAD_DAY = 32'd18483613;
  localparam logic [31:0] ECC_Q30 = 32'd35433480;
  localparam logic [31:0] LN2_Q16 = 32'd45426;
  localparam logic [31:0] EXPO_Q16 = 32'd17367;
  localparam logic [31:0] EATM_COEF = 32'd70779;
  localparam logic [31:0] SOLAR = 32'd1358;
  localparam logic [20:0] LOG_16 = 21'd1048576;

  typedef enum logic [4:0] {
    ST_START, ST_FOLD1, ST_FOLD2, ST_SQ, ST_TM, ST_DIV, ST_FIX, ST_CDONE,
    ST_F, ST_F2, ST_F4, ST_K1, ST_K2, ST_K3,
    ST_L0, ST_LINIT, ST_LIT, ST_LN, ST_P, ST_E, ST_EC, ST_Y, ST_RUN
  } state_t;

  typedef enum logic [1:0] {RET_T, RET_LNV, RET_E} ret_t;

  function automatic logic [7:0] dens(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0: d = 8'd132;
      3'd1: d = 8'd90;
      3'd2: d = 8'd56;
      3'd3: d = 8'd30;
      3'd4: d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / dens(k)); the quotient it yields is at most one short
  function automatic logic [31:0] recip(input logic [2:0] k);
    logic [31:0] rc;
    case (k)
      3'd0: rc = 32'd32537631;
      3'd1: rc = 32'd47721858;
      3'd2: rc = 32'd76695844;
      3'd3: rc = 32'd143165576;
      3'd4: rc = 32'd357913941;
      default: rc = 32'd2147483648;
    endcase
    return rc;
  endfunction

  function automatic logic [4:0] msb20(input logic [19:0] v);
    logic [4:0] e;
    e = 5'd0;
    for (int j = 0; j < 20; j++) begin
      if (v[j]) e = 5'(j);
    end
    return e;
  endfunction

  state_t state;
  ret_t   ret;

  logic [15:0] tsw;
  logic [8:0]  doy;
  logic [13:0] zen;

  logic [32:0] x;
  logic        neg;
  logic        zen_pass;
  logic [31:0] x2;
  logic [30:0] t;
  logic [2:0]  term;
  logic [31:0] dq;
  logic [31:0] q0;
  logic [30:0] cz;
  logic [30:0] cd_mag;
  logic [31:0] f;
  logic [31:0] f2;
  logic [31:0] f4;
  logic [31:0] k1;
  logic [snr_pkg::KIN_W-1:0]  kin;
  logic [snr_pkg::EATM_W-1:0] eatm;
  logic [19:0] log_in;
  logic [30:0] zl;
  logic [20:0] r;
  logic [3:0]  bit_idx;
  logic [15:0] frac;
  logic [5:0]  shr;
  logic [16:0] m;
  logic [3:0]  bt;

  logic [13:0] zen_c;
  logic [8:0]  doy_m;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [20:0] negl;
  logic signed [21:0] ly;
  logic [20:0] ly_mag;
  logic [16:0] y;
  logic [39:0] dmul;
  logic [31:0] drem;
  logic [31:0] qfix;
  logic signed [33:0] tn;
  logic [4:0]  e_l;
  logic [50:0] zsh;
  logic [31:0] zz;
  logic [36:0] lnv_sum;
  logic [20:0] m2;
  logic signed [21:0] p;
  logic [34:0] eatm_sum;
  logic [25:0] ecc_sh;

  always_comb begin
    zen_c = (zen > 14'd9000) ? 14'd9000 : zen;
    doy_m = (doy >= 9'd365) ? doy - 9'd365 : doy;
    negl = LOG_16 - r;
    ly = $signed({1'b0, r}) - $signed({1'b0, LOG_16});
    ly_mag = ly[21] ? 21'(-ly) : ly[20:0];
    y = m >> shr;
    // one correction step after the reciprocal estimate
    dmul = 40'(q0) * 40'(dens(term));
    drem = dq - dmul[31:0];
    qfix = (drem >= 32'(dens(term))) ? q0 + 32'd1 : q0;
    tn = $signed({1'b0, ONE_Q30}) - $signed({2'b0, qfix});
    e_l = msb20(log_in);
    zsh = {31'b0, log_in} << (5'd30 - e_l);
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      ST_START: begin mul_a = 32'(zen_c); mul_b = RAD_CDEG; end
      ST_CDONE: begin mul_a = 32'(doy_m); mul_b = RAD_DAY; end
      ST_SQ:    begin mul_a = x[31:0]; mul_b = x[31:0]; end
      ST_TM:    begin mul_a = x2; mul_b = 32'(t); end
      ST_DIV:   begin mul_a = dq; mul_b = recip(term); end
      ST_F:     begin mul_a = 32'(cd_mag); mul_b = ECC_Q30; end
      ST_F2:    begin mul_a = f; mul_b = f; end
      ST_F4:    begin mul_a = f2; mul_b = f2; end
      ST_K1:    begin mul_a = 32'(cz); mul_b = f4; end
      ST_K2:    begin mul_a = k1; mul_b = 32'(tsw); end
      ST_K3:    begin mul_a = k1; mul_b = SOLAR; end
      ST_LIT:   begin mul_a = 32'(zl); mul_b = 32'(zl); end
      ST_LN:    begin mul_a = 32'(negl); mul_b = LN2_Q16; end
      ST_P:     begin mul_a = 32'(ly_mag); mul_b = EXPO_Q16; end
      ST_Y:     begin mul_a = 32'(y); mul_b = EATM_COEF; end
      default:  begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
    zz = prod[61:30];
    lnv_sum = prod[36:0] + 37'd32768;
    m2 = prod[36:16];
    p = ly[21] ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
    eatm_sum = prod[34:0] + 35'd32768;
    ecc_sh = prod[55:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      tsw <= snr_pkg::TSW_RESET;
      doy <= snr_pkg::DOY_RESET;
      zen <= snr_pkg::ZEN_RESET;
    end else if (cfg_write) begin
      // restart the coefficient pass on every write
      unique case (cfg_index)
        snr_pkg::REG_TSW: tsw <= cfg_data;
        snr_pkg::REG_DOY: doy <= cfg_data[8:0];
        snr_pkg::REG_ZEN: zen <= cfg_data[13:0];
        default: ;
      endcase
      state <= ST_START;
    end else begin
      unique case (state)
        ST_START: begin
          x <= {1'b0, prod[31:0]};
          zen_pass <= 1'b1;
          neg <= 1'b0;
          state <= ST_FOLD1;
        end
        ST_FOLD1: begin
          if (x > PI_Q30) x <= TWO_PI_Q30 - x;
          state <= ST_FOLD2;
        end
        ST_FOLD2: begin
          if (x > HALF_PI_Q30) begin
            x <= PI_Q30 - x;
            neg <= 1'b1;
          end
          state <= ST_SQ;
        end
        ST_SQ: begin
          x2 <= prod[61:30];
          t <= ONE_Q30[30:0];
          term <= 3'd0;
          state <= ST_TM;
        end
        ST_TM: begin
          dq <= prod[61:30];
          state <= ST_DIV;
        end
        ST_DIV: begin
          q0 <= prod[63:32];
          state <= ST_FIX;
        end
        ST_FIX: begin
          t <= tn[33] ? 31'd0 : tn[30:0];
          if (term == 3'd5) begin
            state <= ST_CDONE;
          end else begin
            term <= term + 3'd1;
            state <= ST_TM;
          end
        end
        ST_CDONE: begin
          if (zen_pass) begin
            cz <= t;
            x <= prod[32:0];
            zen_pass <= 1'b0;
            neg <= 1'b0;
            state <= ST_FOLD1;
          end else begin
            cd_mag <= t;
            state <= ST_F;
          end
        end
        ST_F: begin
          f <= neg ? ONE_Q30[31:0] - 32'(ecc_sh) : ONE_Q30[31:0] + 32'(ecc_sh);
          state <= ST_F2;
        end
        ST_F2: begin f2 <= prod[61:30]; state <= ST_F4; end
        ST_F4: begin f4 <= prod[61:30]; state <= ST_K1; end
        ST_K1: begin k1 <= prod[61:30]; state <= ST_K2; end
        ST_K2: begin k1 <= prod[47:16]; state <= ST_K3; end
        ST_K3: begin
          kin <= prod[40:14];
          state <= ST_L0;
        end
        ST_L0: begin
          log_in <= (tsw == 16'd0) ? 20'd1 : 20'(tsw);
          ret <= RET_T;
          state <= ST_LINIT;
        end
        ST_LINIT: begin
          zl <= zsh[30:0];
          r <= {e_l, 16'b0};
          bit_idx <= 4'd15;
          state <= ST_LIT;
        end
        ST_LIT: begin
          if (zz[31]) begin
            zl <= zz[31:1];
            r[bit_idx] <= 1'b1;
          end else begin
            zl <= zz[30:0];
          end
          if (bit_idx == 4'd0) begin
            unique case (ret)
              RET_T:   state <= ST_LN;
              RET_LNV: state <= ST_P;
              RET_E:   state <= ST_EC;
              default: state <= ST_RUN;
            endcase
          end else begin
            bit_idx <= bit_idx - 4'd1;
          end
        end
        ST_LN: begin
          if (lnv_sum[35:16] == 20'd0) begin
            eatm <= '0;
            state <= ST_RUN;
          end else begin
            log_in <= lnv_sum[35:16];
            ret <= RET_LNV;
            state <= ST_LINIT;
          end
        end
        ST_P: begin
          frac <= p[15:0];
          shr <= p[21] ? 6'(-p[21:16]) : 6'd0;
          m <= 17'd65536;
          bt <= 4'd15;
          state <= ST_E;
        end
        ST_E: begin
          log_in <= 20'(m | (17'd1 << bt));
          ret <= RET_E;
          state <= ST_LINIT;
        end
        ST_EC: begin
          if ((r - LOG_16) <= {5'b0, frac}) m <= log_in[16:0];
          if (bt == 4'd0) begin
            state <= ST_Y;
          end else begin
            bt <= bt - 4'd1;
            state <= ST_E;
          end
        end
        ST_Y: begin
          eatm <= eatm_sum[33:16];
          state <= ST_RUN;
        end
        ST_RUN: state <= ST_RUN;
        default: state <= ST_START;
      endcase
    end
  end

  assign coef.ok = (state == ST_RUN);
  assign coef.kin = kin;
  assign coef.eatm = eatm;

endmodule

// ===== src/snr_pipe.sv =====
// Six-stage per-pixel datapath: fourth powers, longwave balance, rounding.
// Depends on snr_pkg for the coefficient struct and the Stefan-Boltzmann root.
module snr_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         albedo,
  input  logic [15:0]         surface_temp,
  input  logic signed [13:0]  air_temp_diff,
  input  logic [15:0]         emissivity,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  net_radiation,
  input  snr_pkg::snr_coef_t  coef
);

  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic [32:0] sqa1;
  logic [31:0] sqs1;
  logic [27:0] sw1, sw2, sw3, sw4, sw5;
  logic [15:0] em1, em2, em3, em4;
  logic [31:0] va2, vs2;
  logic [30:0] fa3, fs3;
  logic [32:0] lsky4;
  logic [30:0] fs4;
  logic signed [50:0] p5;
  logic signed [15:0] res6;

  logic signed [17:0] ta;
  logic [16:0] ta_abs;
  logic [43:0] sw_prod;
  logic [63:0] pa, ps, qa, qs;
  logic [48:0] lsky_prod;
  logic signed [33:0] diff;
  logic signed [50:0] biased;
  logic signed [34:0] lw;
  logic signed [35:0] tot;
  logic signed [35:0] yv;
  logic signed [23:0] q;

  assign rdy6 = !v6 || out_ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1 && coef.ok;

  always_comb begin
    ta = $signed({2'b0, surface_temp}) - 18'(air_temp_diff);
    ta_abs = ta[17] ? 17'(-ta) : ta[16:0];
    sw_prod = 44'(coef.kin) * 44'(17'd65536 - {1'b0, albedo});
    pa = 64'(sqa1) * 64'(snr_pkg::SQRT_SIGMA_K) + 64'd536870912;
    ps = 64'(sqs1) * 64'(snr_pkg::SQRT_SIGMA_K) + 64'd536870912;
    qa = 64'(va2) * 64'(va2) + 64'd2147483648;
    qs = 64'(vs2) * 64'(vs2) + 64'd2147483648;
    lsky_prod = 49'(coef.eatm) * 49'(fa3);
    diff = $signed({1'b0, lsky4}) - $signed({3'b0, fs4});
    biased = p5 + (p5[50] ? 51'sd65535 : 51'sd0);
    lw = biased[50:16];
    tot = $signed({8'b0, sw5}) + $signed({lw[34], lw});
    yv = tot + 36'sd2048;
    q = yv[35:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid && coef.ok;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sqa1 <= 33'(ta_abs) * 33'(ta_abs);
      sqs1 <= 32'(surface_temp) * 32'(surface_temp);
      sw1 <= sw_prod[43:16];
      em1 <= emissivity;
    end
    if (rdy2) begin
      va2 <= pa[61:30];
      vs2 <= ps[61:30];
      sw2 <= sw1;
      em2 <= em1;
    end
    if (rdy3) begin
      fa3 <= qa[62:32];
      fs3 <= qs[62:32];
      sw3 <= sw2;
      em3 <= em2;
    end
    if (rdy4) begin
      lsky4 <= lsky_prod[48:16];
      fs4 <= fs3;
      sw4 <= sw3;
      em4 <= em3;
    end
    if (rdy5) begin
      p5 <= diff * $signed({1'b0, em4});
      sw5 <= sw4;
    end
    if (rdy6) begin
      // saturate to the 1/16 W/m2 range
      if (q > 24'sd32767) res6 <= 16'sh7fff;
      else if (q < -24'sd32768) res6 <= 16'sh8000;
      else res6 <= q[15:0];
    end
  end

  assign out_valid = v6;
  assign net_radiation = res6;

endmodule

// ===== src/surface_net_radiation_top.sv =====
// Top level of the surface net radiation block.
// Depends on snr_pkg, snr_cfg and snr_pipe.
//
// Usage:
//   Write transmissivity, day of year and sun zenith through the write port
//   (cfg_write, cfg_index, cfg_data) once per image, while no pixel is in
//   flight. Each write restarts the coefficient sequencer, which runs two
//   cosine evaluations through a shared 32x32 multiplier, each series
//   division done as a reciprocal multiply and one correction, then the
//   log2/exp2 chain for atmospheric emissivity (sixteen squarings per
//   log2, one per cycle). in_ready stays low until it finishes. The
//   same pass runs after reset.
//   Pixels enter on in_valid/in_ready, one beat per cycle sustained while
//   out_ready stays high; the result beat shows on out_valid/out_ready
//   after the six register stages of the pixel datapath (squares, root
//   flux, fourth power, sky longwave, balance multiply, round and saturate).
//   Reset is synchronous and clears all valid bits. When the receiver stalls,
//   each stage holds its beat and the stall backs up stage by stage; bubbles
//   still fill, and no beat is dropped or repeated.
module surface_net_radiation_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [snr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [snr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     albedo,
  input  logic [15:0]                     surface_temp,
  input  logic signed [13:0]              air_temp_diff,
  input  logic [15:0]                     emissivity,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              net_radiation
);

  snr_pkg::snr_coef_t coef;

  // per-image coefficients
  snr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // per-pixel datapath
  snr_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .albedo        (albedo),
    .surface_temp  (surface_temp),
    .air_temp_diff (air_temp_diff),
    .emissivity    (emissivity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .net_radiation (net_radiation),
    .coef          (coef)
  );

  // a write always blocks pixel intake on the next cycle
  a_cfg_blocks: assert property (@(posedge clk) cfg_write |=> !in_ready)
    else $error("pixel accepted during coefficient recompute");

  // coefficients are lost only through a write or reset
  a_coef_fall: assert property (@(posedge clk)
    $fell(coef.ok) |-> ($past(cfg_write) || $past(rst)))
    else $error("coefficients dropped without cause");

  // reset empties the pipeline and holds intake
  a_reset: assert property (@(posedge clk) rst |=> (!out_valid && !in_ready))
    else $error("pipeline not cleared by reset");

endmodule

// ===== bench/surface_net_radiation_top_test.sv =====
// Self-checking bench for surface_net_radiation_top: directed and random pixels
// under several image settings, results checked against a built-in net radiation model.
// Depends on snr_pkg and the RTL of surface_net_radiation_top.
module surface_net_radiation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint CDEG_Q30    = 64'sd187403;
  localparam longint DAY_Q30     = 64'sd18483613;
  localparam longint ECC_Q30     = 64'sd35433480;
  localparam int     WATCH_LIMIT = 20000;

  logic clk, rst, cfg_write;
  logic [snr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [snr_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] albedo, surface_temp, emissivity;
  logic signed [13:0] air_temp_diff;
  logic signed [15:0] net_radiation;

  // image settings as the bench believes the block holds them
  logic [15:0] tsw_q;
  logic [8:0]  doy_q;
  logic [13:0] zen_q;

  logic signed [15:0] rn_queue[$];
  int  fail_count;
  int  idle_cycles;
  bit  long_stall;
  bit  gaps_on;

  surface_net_radiation_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------- net radiation predictor ----------------
  function automatic longint cosine_q30(longint x);
    longint dens[6] = '{132, 90, 56, 30, 12, 2};
    longint sgn, x2, t;
    sgn = 1;
    t = ONE_Q30;
    if (x < 0) x = 0;
    if (x > TWO_PI_Q30) x = TWO_PI_Q30;
    if (x > PI_Q30) x = TWO_PI_Q30 - x;
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
      sgn = -1;
    end
    x2 = (x * x) / ONE_Q30;
    for (int i = 0; i < 6; i++) t = ONE_Q30 - (x2 * t) / (dens[i] * ONE_Q30);
    if (t < 0) t = 0;
    return sgn * t;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned v);
    int e;
    longint unsigned t, z, r;
    e = 0;
    t = v;
    if (v == 0) return 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    z = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
    r = longint'(e) << 16;
    for (int b = 15; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= (64'd1 << 31)) begin
        z >>= 1;
        r |= 64'd1 << b;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned exp2_fix(longint unsigned f);
    longint unsigned m, c;
    m = 65536;
    for (int b = 15; b >= 0; b--) begin
      c = m | (64'd1 << b);
      if (log2_fix(c) - (64'd16 << 16) <= f) m = c;
    end
    return m;
  endfunction

  function automatic longint unsigned sky_emissivity(logic [15:0] tsw);
    longint unsigned t, negl, lnv, y;
    longint ly, p, n;
    t = (tsw != 0) ? tsw : 1;
    negl = (64'd16 << 16) - log2_fix(t);
    lnv = (negl * 45426 + 32768) >> 16;
    if (lnv == 0) return 0;
    ly = longint'(log2_fix(lnv)) - (64'sd16 << 16);
    p = (ly * 17367) / 65536;
    n = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
    y = exp2_fix(longint'(p - n * 65536));
    if (n >= 0) y = (n > 15) ? (y << 15) : (y << n);
    else y = (-n > 31) ? 0 : (y >> (-n));
    return (y * 70779 + 32768) >> 16;
  endfunction

  function automatic longint unsigned blackbody_flux(longint unsigned tc);
    longint unsigned v;
    v = (tc * tc * snr_pkg::SQRT_SIGMA_K + (64'd1 << 29)) >> 30;
    return (v * v + (64'd1 << 31)) >> 32;
  endfunction

  function automatic logic signed [15:0] predict_rn(logic [15:0] alb, logic [15:0] ts,
                                                    logic signed [13:0] dt, logic [15:0] em);
    longint ta, cz, cd, f, f2, f4, lw, tot, yv, q;
    longint unsigned z, k1, kin, sw, lsky, lsurf;
    ta = longint'(ts) - longint'(dt);
    z = (zen_q > 9000) ? 9000 : zen_q;
    cz = cosine_q30(longint'(z) * CDEG_Q30);
    cd = cosine_q30(longint'(doy_q % 365) * DAY_Q30);
    f = ONE_Q30 + (ECC_Q30 * cd) / ONE_Q30;
    f2 = (f * f) / ONE_Q30;
    f4 = (f2 * f2) / ONE_Q30;
    k1 = (longint'(cz) * longint'(f4)) >> 30;
    k1 = (k1 * tsw_q) >> 16;
    kin = (k1 * 1358) >> 14;
    sw = (kin * (65536 - longint'(alb))) >> 16;
    if (ta < 0) ta = -ta;
    lsky = (sky_emissivity(tsw_q) * blackbody_flux(ta)) >> 16;
    lsurf = blackbody_flux(ts);
    lw = ((longint'(lsky) - longint'(lsurf)) * longint'(em)) / 65536;
    tot = longint'(sw) + lw;
    yv = tot + 2048;
    q = (yv >= 0) ? yv / 4096 : -((-yv + 4095) / 4096);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // ---------------- drivers ----------------
  // Send one pixel beat, after a random gap when gaps_on is set; hold it
  // until accepted. Valid stays high afterwards; the caller drops it (end_burst).
  task automatic send_pixel(logic [15:0] alb, logic [15:0] ts, logic signed [13:0] dt,
                            logic [15:0] em);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    albedo <= alb;
    surface_temp <= ts;
    air_temp_diff <= dt;
    emissivity <= em;
    rn_queue.push_back(predict_rn(alb, ts, dt, em));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 0;
  endtask

  // Wait for the pipe to drain, then program one register; pixels sent
  // after it wait on in_ready until the coefficient pass finishes.
  task automatic write_reg(logic [snr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    end_burst();
    while (rn_queue.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    case (idx)
      snr_pkg::REG_TSW: tsw_q = val;
      snr_pkg::REG_DOY: doy_q = val[8:0];
      default: zen_q = val[13:0];
    endcase
  endtask

  task automatic random_pixel();
    logic [15:0] ts;
    logic signed [13:0] dt;
    ts = (($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40000))
                                       : 16'($urandom_range(25000, 33000)));
    dt = 14'($signed($urandom_range(0, 10000)) - 5000);
    if ($urandom_range(0, 19) == 0) dt = ($urandom_range(0, 1) ? 14'sd5000 : -14'sd5000);
    send_pixel(16'($urandom), ts, dt, 16'($urandom));
  endtask

  // ---------------- tests ----------------
  task automatic test_field_extremes();
    send_pixel(16'd0, 16'd0, 14'sd0, 16'd0);
    send_pixel(16'hFFFF, 16'd40000, 14'sd5000, 16'hFFFF);
    send_pixel(16'd0, 16'd40000, -14'sd5000, 16'hFFFF);
    send_pixel(16'd0, 16'd30000, 14'sd0, 16'd0);
    // air warmer than the surface by more than the surface temperature
    send_pixel(16'd100, 16'd1000, -14'sd5000, 16'd60000);
    // negative air temperature: magnitude is used
    send_pixel(16'd32768, 16'd2000, 14'sd5000, 16'd65000);
    send_pixel(16'h5555, 16'h5555, 14'h1555, 16'hAAAA);
    send_pixel(16'hAAAA, 16'h8AAA, 14'h2AAA, 16'h5555);
    end_burst();
  endtask

  task automatic test_special_settings();
    // transmissivity zero, then nearly one (log term nearly vanishes)
    write_reg(snr_pkg::REG_TSW, 16'd0);
    send_pixel(16'd0, 16'd30000, 14'sd200, 16'd64000);
    write_reg(snr_pkg::REG_TSW, 16'd65535);
    send_pixel(16'd0, 16'd30000, 14'sd200, 16'd64000);
    send_pixel(16'd0, 16'd0, -14'sd5000, 16'hFFFF);
    write_reg(snr_pkg::REG_TSW, 16'd1);
    send_pixel(16'd0, 16'd29000, 14'sd0, 16'hFFFF);
    // zenith overhead and beyond ninety degrees
    write_reg(snr_pkg::REG_ZEN, 16'd0);
    write_reg(snr_pkg::REG_TSW, 16'd65535);
    send_pixel(16'd0, 16'd0, 14'sd0, 16'd0);
    write_reg(snr_pkg::REG_ZEN, 16'd16383);
    send_pixel(16'd0, 16'd30000, 14'sd0, 16'd65535);
    write_reg(snr_pkg::REG_ZEN, 16'd9000);
    send_pixel(16'd0, 16'd30000, 14'sd0, 16'd65535);
    // day zero, day 365, day beyond the year
    write_reg(snr_pkg::REG_ZEN, 16'd0);
    write_reg(snr_pkg::REG_DOY, 16'd0);
    send_pixel(16'd0, 16'd0, 14'sd0, 16'd0);
    write_reg(snr_pkg::REG_DOY, 16'd365);
    send_pixel(16'd0, 16'd0, 14'sd0, 16'd0);
    write_reg(snr_pkg::REG_DOY, 16'd511);
    send_pixel(16'd0, 16'd0, 14'sd0, 16'd0);
    end_burst();
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering
    gaps_on = 0;
    long_stall = 1;
    repeat (60) random_pixel();
    end_burst();
    gaps_on = 1;
  endtask

  task automatic test_random_images();
    logic [15:0] tsw_pick[4] = '{16'd1, 16'd65535, 16'd45875, 16'd20000};
    for (int img = 0; img < 8; img++) begin
      write_reg(snr_pkg::REG_TSW,
                (img < 4) ? tsw_pick[img] : 16'($urandom_range(1, 65535)));
      write_reg(snr_pkg::REG_DOY, 16'($urandom_range(0, 511)));
      write_reg(snr_pkg::REG_ZEN, (img == 0) ? 16'd9000 : 16'($urandom_range(0, 16383)));
      repeat (200) random_pixel();
    end
    end_burst();
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    int hold;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (long_stall) begin
        // one long hold so the pipe fills and in_ready falls
        out_ready <= 0;
        repeat (40) @(negedge clk);
        long_stall = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        hold = $urandom_range(1, 5);
        repeat (hold) @(negedge clk);
      end else begin
        out_ready <= 1;
        hold = $urandom_range(1, 20);
        repeat (hold) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (rn_queue.size() == 0) begin
        $error("unexpected result beat net_radiation=%0d", net_radiation);
        fail_count++;
      end else begin
        if (net_radiation !== rn_queue[0]) begin
          $error("net_radiation: expected %0d, got %0d", rn_queue[0], net_radiation);
          fail_count++;
        end
        void'(rn_queue.pop_front());
      end
    end
  end

  // watchdog: cycles with no accepted beat on either side and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("surface_net_radiation_top test failed");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    fail_count = 0;
    long_stall = 0;
    gaps_on = 1;
    rst = 1;
    cfg_write = 0;
    cfg_index = snr_pkg::REG_TSW;
    cfg_data = 0;
    in_valid = 0;
    albedo = 0;
    surface_temp = 0;
    air_temp_diff = 0;
    emissivity = 0;
    tsw_q = snr_pkg::TSW_RESET;
    doy_q = snr_pkg::DOY_RESET;
    zen_q = snr_pkg::ZEN_RESET;
    repeat (3) @(negedge clk);
    rst <= 0;

    test_field_extremes();
    test_special_settings();
    test_backpressure();
    test_random_images();

    while (rn_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && rn_queue.size() == 0)
      $display("surface_net_radiation_top test passed");
    else
      $display("surface_net_radiation_top test failed");
    $finish;
  end
endmodule
